// File: rtl/wwml_pkg.sv
// shared constants and item type for the weighted window block
package wwml_pkg;

  localparam int MAX_ROW_LEN = 32;
  localparam int POS_W = $clog2(MAX_ROW_LEN);
  localparam int LEN_W = 6;
  localparam int COST_W = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COST_W-1:0] COST_NONE = 16'hFFFF;
  localparam logic [COST_W-1:0] THRESHOLD_RESET = 16'd256;

  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_C = 8'h43;
  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_T = 8'h54;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [COST_W-1:0] cost;
    logic              rejected;
    logic              row_end;
  } item_t;

endpackage

// File: rtl/wwml_front.sv
// front end: accepts items, picks the letter cost and tracks the row position
module wwml_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            symbol,
  input  logic [15:0]           cost_a,
  input  logic [15:0]           cost_c,
  input  logic [15:0]           cost_g,
  input  logic [15:0]           cost_t,
  input  logic                  last_in_row,
  input  logic                  q_full,
  output logic                  q_push,
  output wwml_pkg::item_t       q_item
);
  import wwml_pkg::*;

  logic [POS_W-1:0]  row_position;
  logic [COST_W-1:0] cost;
  logic              row_end;

  always_comb begin
    case (symbol)
      SYM_A:   cost = cost_a;
      SYM_C:   cost = cost_c;
      SYM_G:   cost = cost_g;
      SYM_T:   cost = cost_t;
      default: cost = COST_NONE;
    endcase
  end

  assign row_end  = last_in_row || (row_position == POS_W'(MAX_ROW_LEN - 1));
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign q_item.pos      = row_position;
  assign q_item.cost     = cost;
  assign q_item.rejected = (cost == COST_NONE);
  assign q_item.row_end  = row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
    end else if (q_push) begin
      if (row_end) begin
        row_position <= '0;
      end else begin
        row_position <= row_position + POS_W'(1);
      end
    end
  end

endmodule

// File: rtl/wwml_queue.sv
// short item queue between the front end and the window engine
module wwml_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wwml_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output wwml_pkg::item_t pop_item
);
  import wwml_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/wwml_back.sv
// window engine: extend, drop, reject and row flush, with the output register
module wwml_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         threshold,
  input  logic                q_nonempty,
  input  wwml_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          window_length,
  output logic                last_of_run
);
  import wwml_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_ZERO2,
    S_FLUSH,
    S_SEP
  } state_t;

  state_t            state;
  item_t             cur;
  logic [COST_W-1:0] cost_ring [MAX_ROW_LEN];
  logic [COST_W-1:0] window_cost;
  logic [LEN_W-1:0]  window_len;
  logic [POS_W-1:0]  window_start;

  logic              emit_ok;
  logic              result_load;
  logic [COST_W:0]   cost_sum;
  logic              fits;
  logic [LEN_W-1:0]  len_inc;
  logic [LEN_W-1:0]  len_dec;
  logic              ring_we;

  assign emit_ok     = !out_valid || !out_stall;
  assign result_load = emit_ok && (state inside {S_RUN, S_ZERO2, S_FLUSH, S_SEP});
  assign cost_sum    = {1'b0, window_cost} + {1'b0, cur.cost};
  assign fits        = !cur.rejected && (cost_sum <= {1'b0, threshold});
  assign len_inc     = window_len + LEN_W'(1);
  assign len_dec     = window_len - LEN_W'(1);
  assign q_pop       = (state == S_IDLE) && q_nonempty;
  assign ring_we     = (state == S_RUN) && emit_ok && fits;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      cost_ring[cur.pos] <= cur.cost;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_cost   <= '0;
      window_len    <= '0;
      window_start  <= '0;
      out_valid     <= 1'b0;
      window_length <= '0;
      last_of_run   <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_nonempty) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (emit_ok) begin
            if (fits) begin
              window_cost   <= cost_sum[COST_W-1:0];
              window_len    <= len_inc;
              window_length <= len_inc;
              last_of_run   <= !cur.row_end;
              if (!cur.row_end) begin
                state <= S_IDLE;
              end else if (len_inc > LEN_W'(1)) begin
                state <= S_FLUSH;
              end else begin
                state <= S_SEP;
              end
            end else if (window_len == '0) begin
              window_length <= '0;
              last_of_run   <= 1'b0;
              window_start  <= cur.pos + POS_W'(1);
              window_cost   <= '0;
              state         <= S_ZERO2;
            end else begin
              window_cost   <= window_cost - cost_ring[window_start];
              window_start  <= window_start + POS_W'(1);
              window_len    <= len_dec;
              window_length <= len_dec;
              last_of_run   <= 1'b0;
            end
          end
        end
        S_ZERO2: begin
          if (emit_ok) begin
            window_length <= '0;
            last_of_run   <= !cur.row_end;
            state         <= cur.row_end ? S_SEP : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (emit_ok) begin
            window_len    <= len_dec;
            window_length <= len_dec;
            last_of_run   <= 1'b0;
            if (len_dec <= LEN_W'(1)) begin
              state <= S_SEP;
            end
          end
        end
        S_SEP: begin
          if (emit_ok) begin
            window_length <= '0;
            last_of_run   <= 1'b1;
            window_cost   <= '0;
            window_len    <= '0;
            window_start  <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pop_starts_run: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_RUN))
    else $error("popped item did not start evaluation");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (window_len > LEN_W'(1)))
    else $error("flush entered with window of length one or less");

  a_empty_no_cost: assert property (@(posedge clk) disable iff (rst)
    (window_len == '0) |-> (window_cost == '0))
    else $error("empty window carries nonzero cost");

  a_sep_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SEP) && emit_ok) |=> ((window_len == '0) && (state == S_IDLE)))
    else $error("row separator did not clear the window");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    window_len <= LEN_W'(MAX_ROW_LEN))
    else $error("window longer than a row");
`endif

endmodule

// File: rtl/weighted_window_maximal_lengths.sv
// top level: threshold register, front end, item queue and window engine
// an item's first result is registered in S_RUN, after the queue and the pop in S_IDLE
// the engine takes the next item after the last one's results; the queue holds up to two
// each drop, zero or flush result is a separate load of the engine's output register
// reset clears the window, row position, queue and output; threshold returns to 256
// the cost ring is not cleared; only entries inside the window are read
module weighted_window_maximal_lengths (
  input  logic        clk,
  input  logic        rst,
  input  logic        threshold_cost_write,
  input  logic [15:0] threshold_cost,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  symbol,
  input  logic [15:0] cost_a,
  input  logic [15:0] cost_c,
  input  logic [15:0] cost_g,
  input  logic [15:0] cost_t,
  input  logic        last_in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  window_length,
  output logic        last_of_run
);
  import wwml_pkg::*;

  logic [COST_W-1:0] threshold;
  logic              q_full;
  logic              q_push;
  item_t             push_item;
  logic              q_pop;
  logic              q_nonempty;
  item_t             pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (threshold_cost_write) begin
      threshold <= threshold_cost;
    end
  end

  wwml_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .symbol      (symbol),
    .cost_a      (cost_a),
    .cost_c      (cost_c),
    .cost_g      (cost_g),
    .cost_t      (cost_t),
    .last_in_row (last_in_row),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  wwml_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (pop_item)
  );

  wwml_back u_back (
    .clk           (clk),
    .rst           (rst),
    .threshold     (threshold),
    .q_nonempty    (q_nonempty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .window_length (window_length),
    .last_of_run   (last_of_run)
  );

endmodule

// File: tb/sv/tb_weighted_window_maximal_lengths.sv
// self-checking testbench for the weighted window maximal lengths block
import wwml_pkg::*;

typedef struct {
  logic [5:0] len;
  logic       last;
} length_rec_t;

class window_length_scoreboard;
  int threshold;
  int cost_ring [MAX_ROW_LEN];
  int window_cost;
  int window_len;
  int window_start;
  int row_pos;
  int failures;
  length_rec_t pending_lengths[$];

  function new();
    threshold = THRESHOLD_RESET;
    window_cost = 0;
    window_len = 0;
    window_start = 0;
    row_pos = 0;
    failures = 0;
  endfunction

  function void set_threshold(int value);
    threshold = value;
  endfunction

  function int outstanding();
    return pending_lengths.size();
  endfunction

  function void add_length(int len);
    length_rec_t rec;
    rec.len = 6'(len);
    rec.last = 1'b0;
    pending_lengths.push_back(rec);
  endfunction

  // works out the lengths one accepted item causes
  function void take_symbol(logic [7:0] sym, logic [15:0] ca, logic [15:0] cc,
                            logic [15:0] cg, logic [15:0] ct, logic row_last);
    int pos;
    int cost;
    bit rejected;
    bit done;
    length_rec_t rec;
    pos = row_pos;
    if (pos >= MAX_ROW_LEN) pos = MAX_ROW_LEN - 1;
    case (sym)
      SYM_A: cost = ca;
      SYM_C: cost = cc;
      SYM_G: cost = cg;
      SYM_T: cost = ct;
      default: cost = COST_NONE;
    endcase
    rejected = (cost == COST_NONE);
    done = 1'b0;
    while (!done) begin
      if (!rejected && window_cost + cost <= threshold) begin
        cost_ring[pos] = cost;
        window_cost += cost;
        window_len++;
        add_length(window_len);
        done = 1'b1;
      end else if (window_len == 0) begin
        add_length(0);
        add_length(0);
        window_start = pos + 1;
        window_cost = 0;
        done = 1'b1;
      end else begin
        if (window_start < MAX_ROW_LEN) window_cost -= cost_ring[window_start];
        window_start++;
        window_len--;
        add_length(window_len);
      end
    end
    if (row_last || pos == MAX_ROW_LEN - 1) begin
      while (window_len > 1) begin
        window_len--;
        add_length(window_len);
      end
      add_length(0);
      window_cost = 0;
      window_len = 0;
      window_start = 0;
      row_pos = 0;
    end else begin
      row_pos = pos + 1;
    end
    rec = pending_lengths.pop_back();
    rec.last = 1'b1;
    pending_lengths.push_back(rec);
  endfunction

  function void check_length(logic [5:0] len, logic last);
    length_rec_t rec;
    if (pending_lengths.size() == 0) begin
      $display("%0t: unexpected result window_length %0d last_of_run %0b", $time, len, last);
      failures++;
    end else begin
      rec = pending_lengths.pop_front();
      if (rec.len !== len) begin
        $display("%0t: window_length expected %0d got %0d", $time, rec.len, len);
        failures++;
      end
      if (rec.last !== last) begin
        $display("%0t: last_of_run expected %0b got %0b", $time, rec.last, last);
        failures++;
      end
    end
  endfunction
endclass

module tb_weighted_window_maximal_lengths;
  logic        clk;
  logic        rst;
  logic        threshold_cost_write;
  logic [15:0] threshold_cost;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  symbol;
  logic [15:0] cost_a;
  logic [15:0] cost_c;
  logic [15:0] cost_g;
  logic [15:0] cost_t;
  logic        last_in_row;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  window_length;
  logic        last_of_run;

  window_length_scoreboard sb = new();
  int thr_now = THRESHOLD_RESET;
  int items_sent = 0;
  bit sender_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  bit hold_req = 1'b0;

  weighted_window_maximal_lengths dut (
    .clk(clk),
    .rst(rst),
    .threshold_cost_write(threshold_cost_write),
    .threshold_cost(threshold_cost),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .symbol(symbol),
    .cost_a(cost_a),
    .cost_c(cost_c),
    .cost_g(cost_g),
    .cost_t(cost_t),
    .last_in_row(last_in_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .window_length(window_length),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15000000;
    $display("weighted_window_maximal_lengths verification failed");
    $finish;
  end

  // result side: checks each taken result and stalls in random segments
  initial begin
    int seg_left;
    bit seg_stall;
    seg_left = 0;
    seg_stall = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_length(window_length, last_of_run);
      if (seg_left == 0) begin
        if (hold_req) begin
          hold_req = 1'b0;
          seg_stall = 1'b1;
          seg_left = 300;
        end else if (recv_quiet || $urandom_range(0, 2) != 0) begin
          seg_stall = 1'b0;
          seg_left = $urandom_range(1, 8);
        end else begin
          seg_stall = 1'b1;
          seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
        end
      end
      seg_left--;
      out_stall <= seg_stall;
    end
  end

  task automatic drive_symbol(input logic [7:0] sym, input logic [15:0] ca,
                              input logic [15:0] cc, input logic [15:0] cg,
                              input logic [15:0] ct, input logic row_last);
    in_valid <= 1'b1;
    symbol <= sym;
    cost_a <= ca;
    cost_c <= cc;
    cost_g <= cg;
    cost_t <= ct;
    last_in_row <= row_last;
    do @(posedge clk); while (in_stall);
    sb.take_symbol(sym, ca, cc, cg, ct, row_last);
    items_sent++;
  endtask

  // cost of the named letter is given, the other three are random
  task automatic send_letter(input logic [7:0] sym, input logic [15:0] cost,
                             input logic row_last);
    logic [15:0] ca;
    logic [15:0] cc;
    logic [15:0] cg;
    logic [15:0] ct;
    ca = 16'($urandom);
    cc = 16'($urandom);
    cg = 16'($urandom);
    ct = 16'($urandom);
    case (sym)
      SYM_A: ca = cost;
      SYM_C: cc = cost;
      SYM_G: cg = cost;
      SYM_T: ct = cost;
      default: ;
    endcase
    drive_symbol(sym, ca, cc, cg, ct, row_last);
  endtask

  task automatic sender_gap();
    int r;
    int gap;
    gap = 0;
    if (!sender_quiet) begin
      r = $urandom_range(0, 9);
      if (r >= 9) gap = $urandom_range(5, 20);
      else if (r >= 6) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly costs small next to the threshold so windows grow
  function automatic logic [15:0] pick_cost(int thr);
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 16'($urandom_range(0, thr / 3 + 1));
    if (r < 12) return 16'd0;
    if (r < 13) return COST_NONE;
    if (r < 16) return 16'($urandom);
    return 16'($urandom_range(0, thr));
  endfunction

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 19) >= 17) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return SYM_A;
      1: return SYM_C;
      2: return SYM_G;
      default: return SYM_T;
    endcase
  endfunction

  task automatic send_row(input int len);
    bit row_last;
    for (int i = 0; i < len; i++) begin
      row_last = (i == len - 1) || (len < MAX_ROW_LEN && $urandom_range(0, 39) == 0);
      send_letter(pick_symbol(), pick_cost(thr_now), row_last);
      sender_gap();
    end
  endtask

  task automatic run_rows(input int count);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 19);
      if (r < 16) send_row($urandom_range(1, 10));
      else if (r < 19) send_row($urandom_range(11, 31));
      else send_row($urandom_range(MAX_ROW_LEN, MAX_ROW_LEN + 8));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_threshold(input logic [15:0] value);
    settle();
    threshold_cost_write <= 1'b1;
    threshold_cost <= value;
    @(posedge clk);
    threshold_cost_write <= 1'b0;
    sb.set_threshold(value);
    thr_now = value;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    symbol <= 8'd0;
    cost_a <= 16'd0;
    cost_c <= 16'd0;
    cost_g <= 16'd0;
    cost_t <= 16'd0;
    last_in_row <= 1'b0;
    threshold_cost_write <= 1'b0;
    threshold_cost <= 16'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset threshold: exact fit, drops, unknown letters, zero probability
    send_letter(SYM_A, 16'd64, 1'b0);
    send_letter(SYM_C, 16'd64, 1'b0);
    send_letter(SYM_G, 16'd64, 1'b0);
    send_letter(SYM_T, 16'd64, 1'b0);
    send_letter(SYM_A, 16'd1, 1'b0);
    send_letter(8'h4E, 16'd0, 1'b0);
    send_letter(SYM_G, COST_NONE, 1'b0);
    send_letter(SYM_T, 16'd256, 1'b0);
    send_letter(SYM_C, 16'd0, 1'b0);
    send_letter(8'h00, 16'd0, 1'b0);
    send_letter(8'hFF, 16'd0, 1'b1);
    send_letter(SYM_A, 16'd0, 1'b1);
    send_letter(SYM_C, 16'd257, 1'b1);

    // widest threshold still rejects zero probability
    load_threshold(16'hFFFF);
    send_letter(SYM_A, 16'hFFFE, 1'b0);
    send_letter(SYM_C, COST_NONE, 1'b0);
    send_letter(SYM_G, 16'hFFFE, 1'b0);
    send_letter(SYM_A, 16'd1, 1'b0);
    send_letter(SYM_T, 16'd0, 1'b1);

    load_threshold(16'd0);
    send_letter(SYM_A, 16'd0, 1'b0);
    send_letter(SYM_C, 16'd0, 1'b0);
    send_letter(SYM_G, 16'd1, 1'b0);
    send_letter(SYM_T, 16'd0, 1'b1);

    run_rows(25);
    load_threshold(16'hFFFF);
    send_row(MAX_ROW_LEN + 4);
    run_rows(25);
    load_threshold(16'd1);
    run_rows(20);

    load_threshold(16'($urandom_range(300, 3000)));
    sender_quiet = 1'b1;
    recv_quiet = 1'b1;
    run_rows(30);
    recv_quiet = 1'b0;

    // long receiver hold while items keep coming
    load_threshold(THRESHOLD_RESET);
    hold_req = 1'b1;
    run_rows(25);
    sender_quiet = 1'b0;

    load_threshold(16'($urandom));
    run_rows(15);
    settle();
    run_rows(15);
    load_threshold(16'($urandom_range(512, 4096)));
    run_rows(25);

    settle();
    repeat (24) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("weighted_window_maximal_lengths verification clean");
    end else begin
      $display("weighted_window_maximal_lengths verification failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/wwml_pkg.sv
rtl/wwml_front.sv
rtl/wwml_queue.sv
rtl/wwml_back.sv
rtl/weighted_window_maximal_lengths.sv
tb/sv/tb_weighted_window_maximal_lengths.sv
